>>> hdl/humidity_temp_frame_decoder_top_macros.svh
// Assertion macros for the humidity/temperature frame decoder.
// Used by humidity_temp_frame_decoder_top; expects clk and rst_n in scope.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_TOP_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define HTFD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HTFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HTFD_ASSERT_IMP(lbl, ante, cons)
`define HTFD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hdl/htfd_pkg.sv
// Package for the humidity/temperature frame decoder: widths, byte positions,
// CRC-8 step and the divide-by-65535 helper. No dependencies.
package htfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int TEMP_W    = 15;
    localparam int HUM_W     = 14;
    localparam int OUT_W     = 32;
    localparam int POS_W     = 3;
    localparam int PROD_W    = 31;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    localparam logic [15:0] TEMP_SCALE = 16'd17500;
    localparam logic [15:0] HUM_SCALE  = 16'd12500;
    localparam logic [14:0] TEMP_OFFS  = 15'd4500;
    localparam logic [14:0] HUM_OFFS   = 15'd600;
    localparam logic [14:0] HUM_MAX    = 15'd10000;
    localparam logic [15:0] WORD_MAX   = 16'hFFFF;

    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } pos_t;

    // CRC-8, MSB first, one byte fully unrolled
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // floor(x / 65535) for x < 17501 * 65535: x = q0*65536 + lo = q0*65535 + (lo + q0)
    function automatic logic [14:0] div_65535(input logic [PROD_W-1:0] x);
        logic [14:0] q0;
        logic [16:0] r;
        q0 = x[PROD_W-1:16];
        r  = {1'b0, x[15:0]} + {2'b00, q0};
        return q0 + {14'd0, (r >= {1'b0, WORD_MAX})};
    endfunction

endpackage

>>> hdl/humidity_temp_frame_decoder_top.sv
// The result of a frame passes the input register, stage 1, stage 2 and the output register to m_axis.
// Throughput: one byte per cycle unless m_axis back-pressure fills the pipeline; one result per six bytes.
// Stages: input register -> byte/CRC state update -> scale multiply -> divide/offset/clamp.
// Reset (rst_n low, async): all stages empty, byte count 0, running CRC all ones.
// Uses htfd_pkg and humidity_temp_frame_decoder_top_macros.svh.
`include "humidity_temp_frame_decoder_top_macros.svh"

module humidity_temp_frame_decoder_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [htfd_pkg::BYTE_W-1:0] s_axis_tdata,  // [7:0] data_byte
    input  logic                        s_axis_tuser,  // [0] frame_start
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [14:0] temp_centi_c, [28:15] humidity_centi_pct, [29] temp_crc_ok,
    // [30] humidity_crc_ok, [31] sample_valid
    output logic [htfd_pkg::OUT_W-1:0]  m_axis_tdata
);

    // input register
    logic                        in_valid_reg;
    logic [htfd_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        in_start_reg;

    // frame state
    logic [htfd_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]                  crc_reg, crc_next;
    logic [15:0]                 temp_word_reg, temp_word_next;
    logic [7:0]                  hum_hi_reg, hum_hi_next;
    logic [7:0]                  hum_lo_reg, hum_lo_next;
    logic                        t_ok_reg, t_ok_next;

    // stage 1: raw words
    logic                        p1_valid_reg;
    logic [15:0]                 p1_temp_reg, p1_hum_reg;
    logic                        p1_t_ok_reg, p1_h_ok_reg;

    // stage 2: scaled products
    logic                        p2_valid_reg;
    logic [htfd_pkg::PROD_W-1:0] p2_temp_reg, p2_hum_reg;
    logic                        p2_t_ok_reg, p2_h_ok_reg;

    // output register
    logic                        out_valid_reg;
    logic [htfd_pkg::OUT_W-1:0]  out_data_reg;

    logic [htfd_pkg::POS_W-1:0]  pos_eff;
    logic                        is_last;
    logic                        h_ok;
    logic                        out_free, p2_free, p1_free, in_fire;
    logic [14:0]                 q_t, q_h;
    logic [14:0]                 temp_val;
    logic [13:0]                 hum_val;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign p2_free  = !p2_valid_reg || out_free;
    assign p1_free  = !p1_valid_reg || p2_free;

    // frame start or an out-of-range count restarts the frame
    assign pos_eff = (in_start_reg || pos_reg > htfd_pkg::POS_W'(htfd_pkg::POS_H_CRC))
                     ? htfd_pkg::POS_W'(htfd_pkg::POS_T_HI) : pos_reg;
    assign is_last = (pos_eff == htfd_pkg::POS_W'(htfd_pkg::POS_H_CRC));
    assign in_fire = in_valid_reg && (!is_last || p1_free);
    assign h_ok    = (crc_reg == in_byte_reg);

    assign s_axis_tready = !in_valid_reg || in_fire;

    always_comb
    begin
        pos_next       = pos_eff + 3'd1;
        crc_next       = crc_reg;
        temp_word_next = temp_word_reg;
        hum_hi_next    = hum_hi_reg;
        hum_lo_next    = hum_lo_reg;
        t_ok_next      = t_ok_reg;
        case (htfd_pkg::pos_t'(pos_eff))
            htfd_pkg::POS_T_HI:
            begin
                crc_next       = htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, in_byte_reg);
                temp_word_next = {in_byte_reg, 8'h00};
            end
            htfd_pkg::POS_T_LO:
            begin
                crc_next       = htfd_pkg::crc8_byte(crc_reg, in_byte_reg);
                temp_word_next = {temp_word_reg[15:8], in_byte_reg};
            end
            htfd_pkg::POS_T_CRC:
            begin
                t_ok_next = (crc_reg == in_byte_reg);
                crc_next  = htfd_pkg::CRC_INIT;
            end
            htfd_pkg::POS_H_HI:
            begin
                crc_next    = htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, in_byte_reg);
                hum_hi_next = in_byte_reg;
            end
            htfd_pkg::POS_H_LO:
            begin
                crc_next    = htfd_pkg::crc8_byte(crc_reg, in_byte_reg);
                hum_lo_next = in_byte_reg;
            end
            default:
            begin
                crc_next = htfd_pkg::CRC_INIT;
                pos_next = htfd_pkg::POS_W'(htfd_pkg::POS_T_HI);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            crc_reg       <= htfd_pkg::CRC_INIT;
            temp_word_reg <= '0;
            hum_hi_reg    <= '0;
            hum_lo_reg    <= '0;
            t_ok_reg      <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (in_fire)
            begin
                pos_reg       <= pos_next;
                crc_reg       <= crc_next;
                temp_word_reg <= temp_word_next;
                hum_hi_reg    <= hum_hi_next;
                hum_lo_reg    <= hum_lo_next;
                t_ok_reg      <= t_ok_next;
            end
            if (p1_free)
                p1_valid_reg <= in_fire && is_last;
            if (p2_free)
                p2_valid_reg <= p1_valid_reg;
            if (out_free)
                out_valid_reg <= p2_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
        if (p1_free && in_fire && is_last)
        begin
            p1_temp_reg <= temp_word_reg;
            p1_hum_reg  <= {hum_hi_reg, hum_lo_reg};
            p1_t_ok_reg <= t_ok_reg;
            p1_h_ok_reg <= h_ok;
        end
        if (p2_free && p1_valid_reg)
        begin
            p2_temp_reg <= htfd_pkg::PROD_W'(p1_temp_reg)
                           * htfd_pkg::PROD_W'(htfd_pkg::TEMP_SCALE);
            p2_hum_reg  <= htfd_pkg::PROD_W'(p1_hum_reg)
                           * htfd_pkg::PROD_W'(htfd_pkg::HUM_SCALE);
            p2_t_ok_reg <= p1_t_ok_reg;
            p2_h_ok_reg <= p1_h_ok_reg;
        end
        if (out_free && p2_valid_reg)
            out_data_reg <= {p2_t_ok_reg && p2_h_ok_reg, p2_h_ok_reg, p2_t_ok_reg,
                             hum_val, temp_val};
    end

    assign q_t      = htfd_pkg::div_65535(p2_temp_reg);
    assign q_h      = htfd_pkg::div_65535(p2_hum_reg);
    assign temp_val = q_t - htfd_pkg::TEMP_OFFS;  // two's complement, -4500..13000

    always_comb
    begin
        if (q_h < htfd_pkg::HUM_OFFS)
            hum_val = '0;
        else if (q_h - htfd_pkg::HUM_OFFS > htfd_pkg::HUM_MAX)
            hum_val = htfd_pkg::HUM_W'(htfd_pkg::HUM_MAX);
        else
            hum_val = htfd_pkg::HUM_W'(q_h - htfd_pkg::HUM_OFFS);
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `HTFD_ASSERT_IMP(a_pos_range, 1'b1, pos_reg <= htfd_pkg::POS_W'(htfd_pkg::POS_H_CRC))
    `HTFD_ASSERT_IMP(a_valid_flags, m_axis_tvalid && m_axis_tdata[31],
                     m_axis_tdata[30] && m_axis_tdata[29])
    `HTFD_ASSERT_IMP(a_hum_clamp, m_axis_tvalid, m_axis_tdata[28:15] <= 14'd10000)
    `HTFD_ASSERT_NEXT(a_frame_end, in_fire && is_last,
                      pos_reg == htfd_pkg::POS_W'(htfd_pkg::POS_T_HI)
                      && crc_reg == htfd_pkg::CRC_INIT)

endmodule
